// ===== rtl/stb_pkg.sv =====
package stb_pkg;

   localparam int NUM_TIMERS_DEF    = 16;
   localparam int FOREVER_LIMIT_DEF = 255;

   // request kinds
   localparam logic [2:0] KIND_TICK    = 3'd0;
   localparam logic [2:0] KIND_CREATE  = 3'd1;
   localparam logic [2:0] KIND_ALTER   = 3'd2;
   localparam logic [2:0] KIND_DELETE  = 3'd3;
   localparam logic [2:0] KIND_COLLECT = 3'd4;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NONE      = 2'd3;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  timer_id;
      logic [15:0] interval;
      logic [15:0] lifecycle;
      logic        start_req;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] timer_id_res;
      logic       retired;
      logic [4:0] timers_in_use;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_COLLECT
   } ctl_state_type;

   typedef struct packed {
      logic sweep_step;
      logic tick_done;
      logic collect_step;
   } ctl_cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic any_fire;
      logic fire_last;
   } ctl_sts_type;

endpackage

// ===== rtl/software_timer_bank_unit.sv =====
// Bank of NUM_TIMERS periodic timer slots, IDs 1..NUM_TIMERS.
// Request channel: present req_payload with start high; the beat is taken
// at a clock edge where start is high and busy is low.
// Kinds: tick, create, alter, delete, collect.
// Result channel: rsp_valid marks each result beat for exactly one cycle;
// the receiver cannot stall it. rsp_payload.last flags the final beat.
// Create, alter, delete, unused kinds and an empty collect answer in the
// cycle after the request; busy stays low and a new request may follow.
// Tick: the slot sweep reads one slot per cycle from the interval, repeat
// and counter memories and writes it back in the cycle after; busy stays
// high for the whole sweep and the result follows the last write-back.
// Collect with fired slots: one result per fired slot on consecutive
// cycles in ascending ID order, issued from the controller's collect state.
// Reset (synchronous) frees all slots and clears all pending marks; no
// clearing pass runs, the block takes requests right after reset.
module software_timer_bank_unit #(
   parameter int NUM_TIMERS    = stb_pkg::NUM_TIMERS_DEF,
   parameter int FOREVER_LIMIT = stb_pkg::FOREVER_LIMIT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  stb_pkg::req_type req_payload,
   output logic             rsp_valid,
   output stb_pkg::rsp_type rsp_payload
);
   import stb_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;
   logic        accept;

   assign accept = start && !busy;

   stb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_kind (req_payload.kind),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   stb_datapath #(
      .NUM_TIMERS    (NUM_TIMERS),
      .FOREVER_LIMIT (FOREVER_LIMIT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_payload),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_payload)
   );

endmodule

// ===== rtl/stb_ctrl.sv =====
module stb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [2:0]          req_kind,
   input  stb_pkg::ctl_sts_type sts,
   output stb_pkg::ctl_cmd_type cmd,
   output logic                busy
);
   import stb_pkg::*;

   ctl_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_kind == KIND_TICK) begin
               state_in = ST_TICK;
            end else if (accept && req_kind == KIND_COLLECT && sts.any_fire) begin
               state_in = ST_COLLECT;
            end
         end
         ST_TICK: begin
            if (sts.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_COLLECT: begin
            if (sts.fire_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: busy = 1'b0;
         ST_TICK: begin
            cmd.sweep_step = 1'b1;
            cmd.tick_done  = sts.sweep_last;
         end
         ST_COLLECT: cmd.collect_step = 1'b1;
         default: busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/stb_datapath.sv =====
module stb_datapath #(
   parameter int NUM_TIMERS    = stb_pkg::NUM_TIMERS_DEF,
   parameter int FOREVER_LIMIT = stb_pkg::FOREVER_LIMIT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  stb_pkg::req_type     req,
   input  stb_pkg::ctl_cmd_type cmd,
   output stb_pkg::ctl_sts_type sts,
   output logic                 rsp_valid,
   output stb_pkg::rsp_type     rsp
);
   import stb_pkg::*;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);

   logic [NUM_TIMERS-1:0] valid_ff, valid_in, enabled_ff, enabled_in;
   logic [NUM_TIMERS-1:0] pending_ff, pending_in, rzero_ff, rzero_in;
   logic [CNT_W-1:0]      in_use_ff, in_use_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  proc_vld_ff, proc_vld_in;
   logic [IDX_W-1:0]      proc_idx_ff, proc_idx_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [15:0] int_mem [NUM_TIMERS];
   logic [15:0] rep_mem [NUM_TIMERS];
   logic [15:0] cnt_mem [NUM_TIMERS];
   logic [15:0] rd_int_ff, rd_rep_ff, rd_cnt_ff;
   logic [IDX_W-1:0] rd_addr;

   logic             int_we, rep_we, cnt_we;
   logic [IDX_W-1:0] int_wa, rep_wa, cnt_wa;
   logic [15:0]      int_wd, rep_wd, cnt_wd;

   logic             any_free;
   logic [IDX_W-1:0] free_idx;
   logic             id_ok, id_hit;
   logic [IDX_W-1:0] tgt_idx;
   logic [NUM_TIMERS-1:0] fire, gone, fire_rest;
   logic [CNT_W-1:0] gone_cnt;
   logic [IDX_W-1:0] fire_idx;
   logic             tp_act;
   logic [15:0]      new_rep;

   // lowest free slot
   always_comb begin
      any_free = 1'b0;
      free_idx = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            any_free = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   // target lookup for alter and delete
   assign id_ok   = (req.timer_id != 8'd0) && (9'(req.timer_id) <= 9'(NUM_TIMERS));
   assign tgt_idx = IDX_W'(req.timer_id - 8'd1);
   assign id_hit  = id_ok && valid_ff[tgt_idx];

   // fired slots, retire count and lowest fired slot
   assign fire = valid_ff & enabled_ff & pending_ff;
   assign gone = fire & rzero_ff;
   always_comb begin
      gone_cnt = '0;
      fire_idx = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         gone_cnt = gone_cnt + CNT_W'(gone[i]);
      end
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (fire[i]) begin
            fire_idx = IDX_W'(i);
         end
      end
   end
   assign fire_rest = fire & ~(NUM_TIMERS'(1) << fire_idx);

   assign sts.sweep_last = (idx_ff == CNT_W'(NUM_TIMERS));
   assign sts.any_fire   = |fire;
   assign sts.fire_last  = (fire_rest == '0);

   // tick update for the slot whose data was read last cycle
   assign tp_act  = proc_vld_ff && valid_ff[proc_idx_ff] && enabled_ff[proc_idx_ff]
                    && !rzero_ff[proc_idx_ff];
   assign new_rep = (32'(rd_rep_ff) < FOREVER_LIMIT) ? rd_rep_ff - 16'd1 : rd_rep_ff;
   assign rd_addr = (idx_ff < CNT_W'(NUM_TIMERS)) ? IDX_W'(idx_ff) : '0;

   always_comb begin
      valid_in     = valid_ff;
      enabled_in   = enabled_ff;
      pending_in   = pending_ff;
      rzero_in     = rzero_ff;
      in_use_in    = in_use_ff;
      idx_in       = idx_ff;
      proc_vld_in  = 1'b0;
      proc_idx_in  = proc_idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      int_we = 1'b0; int_wa = free_idx; int_wd = req.interval;
      rep_we = 1'b0; rep_wa = free_idx; rep_wd = req.lifecycle;
      cnt_we = 1'b0; cnt_wa = free_idx; cnt_wd = 16'd0;

      // take a new request beat
      if (accept) begin
         rsp_in.status       = ST_OK;
         rsp_in.timer_id_res = 5'd0;
         rsp_in.retired      = 1'b0;
         rsp_in.last         = 1'b1;
         case (req.kind)
            KIND_TICK: idx_in = '0;
            KIND_CREATE: begin
               rsp_valid_in = 1'b1;
               if (any_free) begin
                  valid_in[free_idx]   = 1'b1;
                  enabled_in[free_idx] = req.start_req;
                  pending_in[free_idx] = 1'b0;
                  rzero_in[free_idx]   = (req.lifecycle == 16'd0);
                  int_we = 1'b1;
                  rep_we = 1'b1;
                  cnt_we = 1'b1;
                  in_use_in = in_use_ff + CNT_W'(1);
                  rsp_in.timer_id_res = 5'(32'(free_idx) + 1);
               end else begin
                  rsp_in.status = ST_FULL;
               end
            end
            KIND_ALTER: begin
               rsp_valid_in = 1'b1;
               if (id_hit) begin
                  rzero_in[tgt_idx] = (req.lifecycle == 16'd0);
                  int_we = 1'b1; int_wa = tgt_idx;
                  rep_we = 1'b1; rep_wa = tgt_idx;
                  cnt_we = 1'b1; cnt_wa = tgt_idx;
                  rsp_in.timer_id_res = 5'(req.timer_id);
               end else begin
                  rsp_in.status = ST_NOT_FOUND;
               end
            end
            KIND_DELETE: begin
               rsp_valid_in = 1'b1;
               if (id_hit) begin
                  valid_in[tgt_idx]   = 1'b0;
                  pending_in[tgt_idx] = 1'b0;
                  in_use_in = in_use_ff - CNT_W'(1);
                  rsp_in.timer_id_res = 5'(req.timer_id);
               end else begin
                  rsp_in.status = ST_NOT_FOUND;
               end
            end
            KIND_COLLECT: begin
               in_use_in = in_use_ff - gone_cnt;
               if (!(|fire)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = ST_NONE;
               end
            end
            default: rsp_valid_in = 1'b1;
         endcase
      end

      // advance the slot sweep
      if (cmd.sweep_step) begin
         proc_vld_in = (idx_ff < CNT_W'(NUM_TIMERS));
         proc_idx_in = rd_addr;
         idx_in      = idx_ff + CNT_W'(1);
      end

      if (tp_act) begin
         if (rd_cnt_ff < rd_int_ff) begin
            cnt_we = 1'b1; cnt_wa = proc_idx_ff; cnt_wd = rd_cnt_ff + 16'd1;
         end else begin
            rep_we = 1'b1; rep_wa = proc_idx_ff; rep_wd = new_rep;
            rzero_in[proc_idx_ff]   = (new_rep == 16'd0);
            pending_in[proc_idx_ff] = 1'b1;
            if (new_rep != 16'd0) begin
               cnt_we = 1'b1; cnt_wa = proc_idx_ff; cnt_wd = 16'd0;
            end
         end
      end

      if (cmd.tick_done) begin
         rsp_valid_in        = 1'b1;
         rsp_in.status       = ST_OK;
         rsp_in.timer_id_res = 5'd0;
         rsp_in.retired      = 1'b0;
         rsp_in.last         = 1'b1;
      end

      // emit the lowest fired slot, retire it if exhausted
      if (cmd.collect_step) begin
         pending_in[fire_idx] = 1'b0;
         if (rzero_ff[fire_idx]) begin
            valid_in[fire_idx] = 1'b0;
         end
         rsp_valid_in        = 1'b1;
         rsp_in.status       = ST_OK;
         rsp_in.timer_id_res = 5'(32'(fire_idx) + 1);
         rsp_in.retired      = rzero_ff[fire_idx];
         rsp_in.last         = (fire_rest == '0);
      end

      rsp_in.timers_in_use = 5'(in_use_in);
   end

   // slot memories
   always_ff @(posedge clock) begin
      if (int_we) begin
         int_mem[int_wa] <= int_wd;
      end
      rd_int_ff <= int_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (rep_we) begin
         rep_mem[rep_wa] <= rep_wd;
      end
      rd_rep_ff <= rep_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      rd_cnt_ff <= cnt_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         enabled_ff   <= '0;
         pending_ff   <= '0;
         rzero_ff     <= '0;
         in_use_ff    <= '0;
         idx_ff       <= '0;
         proc_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         enabled_ff   <= enabled_in;
         pending_ff   <= pending_in;
         rzero_ff     <= rzero_in;
         in_use_ff    <= in_use_in;
         idx_ff       <= idx_in;
         proc_vld_ff  <= proc_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold payload
   always_ff @(posedge clock) begin
      proc_idx_ff <= proc_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== rtl/stb_checker.sv =====
module stb_checker #(
   parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input stb_pkg::req_type req_payload,
   input logic             rsp_valid,
   input stb_pkg::rsp_type rsp_payload
);
   import stb_pkg::*;

   // single-beat kinds answer on the next cycle with one final beat
   a_quick_answer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_payload.kind == KIND_CREATE || req_payload.kind == KIND_ALTER
         || req_payload.kind == KIND_DELETE || req_payload.kind > KIND_COLLECT))
      |=> (rsp_valid && rsp_payload.last))
      else $error("single-beat request not answered next cycle");

   // a collect burst runs back to back until its final beat
   a_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.last) |=> rsp_valid)
      else $error("collect burst broken");

   // error results carry no ID and no retire mark
   a_err_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != ST_OK)
      |-> (rsp_payload.timer_id_res == 5'd0 && !rsp_payload.retired))
      else $error("error result with ID");

   // table full only when every slot is in use
   a_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == ST_FULL)
      |-> (rsp_payload.timers_in_use == 5'(NUM_TIMERS)))
      else $error("full reported with free slots");

endmodule

bind software_timer_bank_unit stb_checker #(.NUM_TIMERS(NUM_TIMERS)) u_stb_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);
